/* rtl/psbl_pkg.sv */
// Shared types, constants and helper functions of the projected SOR box LCP solver.
package psbl_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DEF_MAX_ROWS  = 64;
    localparam int DEF_FRAC_BITS = 16;

    // Most rows a solve can report, fixed by the six-bit row fields.
    localparam int OUT_LIMIT  = 64;
    localparam int RELAX_FRAC = 14;
    localparam int QDEPTH     = 2;

    // Command opcodes.
    localparam logic [1:0] OP_LOAD_MAT = 2'd0;
    localparam logic [1:0] OP_LOAD_ROW = 2'd1;
    localparam logic [1:0] OP_SOLVE    = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ROW_COUNT   = 2'd0;
    localparam logic [1:0] CFG_SWEEP_COUNT = 2'd1;
    localparam logic [1:0] CFG_RELAXATION  = 2'd2;

    // One queued command.
    typedef struct packed {
        logic [1:0]         op;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] matrix_value;
        logic signed [31:0] rhs_value;
        logic signed [31:0] lower_bound;
        logic signed [31:0] upper_bound;
    } cmd_t;

    // Configuration seen by the solver.
    typedef struct packed {
        logic [6:0]  row_count;
        logic [7:0]  sweep_count;
        logic [14:0] relaxation;
    } cfg_t;

    // Rows that can actually be addressed.
    function automatic int eff_rows(input int m);
        return (m < OUT_LIMIT) ? m : OUT_LIMIT;
    endfunction

    // Index bits needed for the addressable rows.
    function automatic int idx_bits(input int m);
        return (eff_rows(m) > 1) ? $clog2(eff_rows(m)) : 1;
    endfunction

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sh000000007fffffff)
        begin
            r = 32'sh7fffffff;
        end
        else if (x < 64'shffffffff80000000)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

/* rtl/psbl_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module psbl_ram #(
    parameter int W = 32,
    parameter int D = 64
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
    input  logic [W-1:0]                        wdata,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
    output logic [W-1:0]                        rdata
);

    logic [W-1:0] mem [D];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/psbl_div.sv */
// Iterative signed divider, one quotient bit per cycle, result saturated to 32 bits.
module psbl_div #(
    parameter int NUM_W = 48
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [31:0]      den,
    output logic                    done,
    output logic signed [31:0]      quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             run_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [31:0]      rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [31:0]      dmag_reg;
    logic             neg_reg;
    logic             done_reg;
    logic signed [31:0] quot_reg;

    logic [32:0]      shifted;
    logic             fits;
    logic [NUM_W-1:0] pos_lim;
    logic [NUM_W-1:0] neg_lim;

    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign fits    = (shifted >= {1'b0, dmag_reg});
    assign pos_lim = NUM_W'(32'h7fffffff);
    assign neg_lim = NUM_W'(33'h080000000);

    // Control of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(NUM_W);
            end
            else if (run_reg && cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            else if (run_reg)
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Restoring division on magnitudes, then sign and saturation.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            dmag_reg <= den[31] ? 32'(-den) : 32'(den);
            neg_reg  <= num[NUM_W-1] ^ den[31];
            rem_reg  <= '0;
        end
        else if (run_reg && cnt_reg != '0)
        begin
            rem_reg <= fits ? 32'(shifted - {1'b0, dmag_reg}) : shifted[31:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
        else if (run_reg)
        begin
            if (!neg_reg)
            begin
                quot_reg <= (quo_reg > pos_lim) ? 32'sh7fffffff : $signed(quo_reg[31:0]);
            end
            else
            begin
                quot_reg <= (quo_reg > neg_lim) ? 32'sh80000000 : $signed(-quo_reg[31:0]);
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* rtl/psbl_front.sv */
// Command front end: accepts items, drops ignored ones and queues the rest.
module psbl_front #(
    parameter int MAX_ROWS = psbl_pkg::DEF_MAX_ROWS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  psbl_pkg::cmd_t       cmd_in,
    output logic                 head_valid,
    output psbl_pkg::cmd_t       head,
    input  logic                 pop
);

    localparam int N_EFF = psbl_pkg::eff_rows(MAX_ROWS);
    localparam int PW    = (psbl_pkg::QDEPTH > 1) ? $clog2(psbl_pkg::QDEPTH) : 1;

    psbl_pkg::cmd_t q_mem [psbl_pkg::QDEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW:0]    count_reg;
    logic           keep;
    logic           push;
    logic           row_ok;
    logic           col_ok;

    // Classify: loads out of range and the unused opcode are dropped.
    assign row_ok = (32'(cmd_in.row) < N_EFF);
    assign col_ok = (32'(cmd_in.col) < N_EFF);
    always_comb
    begin
        unique case (cmd_in.op)
            psbl_pkg::OP_LOAD_MAT: keep = row_ok && col_ok;
            psbl_pkg::OP_LOAD_ROW: keep = row_ok;
            psbl_pkg::OP_SOLVE:    keep = 1'b1;
            default:               keep = 1'b0;
        endcase
    end

    assign busy       = (count_reg == (PW + 1)'(psbl_pkg::QDEPTH));
    assign push       = start && !busy && keep;
    assign head_valid = (count_reg != '0);
    assign head       = q_mem[rd_ptr_reg];

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == psbl_pkg::QDEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == psbl_pkg::QDEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (PW + 1)'(push) - (PW + 1)'(pop);
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

/* rtl/psbl_engine.sv */
// Back end: executes loads and runs the projected SOR (relaxed Gauss-Seidel) solve.
module psbl_engine #(
    parameter int MAX_ROWS  = psbl_pkg::DEF_MAX_ROWS,
    parameter int FRAC_BITS = psbl_pkg::DEF_FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  psbl_pkg::cfg_t     cfg,
    input  logic               head_valid,
    input  psbl_pkg::cmd_t     head,
    output logic               pop,
    output logic               done,
    output logic [5:0]         row_index,
    output logic signed [31:0] multiplier,
    output logic               zero_diagonal,
    output logic               last
);

    localparam int N_EFF = psbl_pkg::eff_rows(MAX_ROWS);
    localparam int AW    = psbl_pkg::idx_bits(MAX_ROWS);
    localparam int CW    = AW + 1;
    localparam int NUM_W = 32 + FRAC_BITS;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_COPY  = 4'd1;
    localparam logic [3:0] S_ROW   = 4'd2;
    localparam logic [3:0] S_DIAG  = 4'd3;
    localparam logic [3:0] S_SUM   = 4'd4;
    localparam logic [3:0] S_DRAIN = 4'd5;
    localparam logic [3:0] S_RES   = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_MUL   = 4'd8;
    localparam logic [3:0] S_UPD   = 4'd9;
    localparam logic [3:0] S_NEXT  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [7:0]    k_reg, k_next;
    logic          cp_v_reg, cp_v_next;
    logic [CW-1:0] cp_a_reg, cp_a_next;
    logic          s1_v_reg, s1_v_next;
    logic          s2_v_reg;
    logic          o_v_reg, o_v_next;
    logic [CW-1:0] o_a_reg, o_a_next;
    logic          done_reg;
    logic          last_reg;

    logic signed [31:0] diag_reg, rhs_reg, lo_reg, up_reg, m_reg, sum_reg, d_reg;
    logic signed [63:0] prod_reg;
    logic signed [47:0] rp_reg;
    logic [5:0]         ri_reg;
    logic signed [31:0] mo_reg;
    logic               zd_reg;

    logic [CW-1:0]      n_solve;
    logic               div_start;
    logic               div_done;
    logic signed [31:0] div_q;
    logic signed [31:0] res;
    logic signed [31:0] nv_raw;
    logic signed [31:0] nv;

    // Memory ports.
    logic            mat_we, row_we, mul_we;
    logic [2*AW-1:0] mat_waddr, mat_raddr;
    logic [AW-1:0]   row_waddr, rhs_raddr, br_raddr, mul_waddr, mul_raddr;
    logic [31:0]     mul_wdata;
    logic [31:0]     mat_q, rhs_q, lo_q, up_q, mul_q;

    psbl_ram #(.W(32), .D(2 ** (2 * AW))) u_mat (
        .clk(clk), .we(mat_we), .waddr(mat_waddr), .wdata(head.matrix_value),
        .raddr(mat_raddr), .rdata(mat_q));
    psbl_ram #(.W(32), .D(2 ** AW)) u_rhs (
        .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(head.rhs_value),
        .raddr(rhs_raddr), .rdata(rhs_q));
    psbl_ram #(.W(32), .D(2 ** AW)) u_lo (
        .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(head.lower_bound),
        .raddr(br_raddr), .rdata(lo_q));
    psbl_ram #(.W(32), .D(2 ** AW)) u_up (
        .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(head.upper_bound),
        .raddr(br_raddr), .rdata(up_q));
    psbl_ram #(.W(32), .D(2 ** AW)) u_mul (
        .clk(clk), .we(mul_we), .waddr(mul_waddr), .wdata(mul_wdata),
        .raddr(mul_raddr), .rdata(mul_q));

    psbl_div #(.NUM_W(NUM_W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num({res, FRAC_BITS'(0)}), .den(diag_reg), .done(div_done), .quot(div_q));

    // Rows in use, limited to the addressable ones.
    assign n_solve = (32'(cfg.row_count) > N_EFF) ? CW'(N_EFF) : cfg.row_count[CW-1:0];

    // Loads are carried out as they leave the queue.
    assign pop       = (state_reg == S_IDLE) && head_valid;
    assign mat_we    = pop && (head.op == psbl_pkg::OP_LOAD_MAT);
    assign row_we    = pop && (head.op == psbl_pkg::OP_LOAD_ROW);
    assign mat_waddr = {head.row[AW-1:0], head.col[AW-1:0]};
    assign row_waddr = head.row[AW-1:0];

    // Read address selection.
    always_comb
    begin
        case (state_reg)
            S_SUM:   mat_raddr = {i_reg[AW-1:0], j_reg[AW-1:0]};
            S_OUT:   mat_raddr = {j_reg[AW-1:0], j_reg[AW-1:0]};
            default: mat_raddr = {i_reg[AW-1:0], i_reg[AW-1:0]};
        endcase
        case (state_reg)
            S_SUM, S_OUT: mul_raddr = j_reg[AW-1:0];
            default:      mul_raddr = i_reg[AW-1:0];
        endcase
    end
    assign rhs_raddr = (state_reg == S_COPY) ? j_reg[AW-1:0] : i_reg[AW-1:0];
    assign br_raddr  = i_reg[AW-1:0];

    // Row update arithmetic.
    assign res       = psbl_pkg::sat32(64'(rhs_reg) - 64'(sum_reg));
    assign div_start = (state_reg == S_RES);
    assign nv_raw    = psbl_pkg::sat32(64'(m_reg) + 64'(rp_reg >>> psbl_pkg::RELAX_FRAC));
    always_comb
    begin
        if (nv_raw < lo_reg)
        begin
            nv = lo_reg;
        end
        else if (nv_raw > up_reg)
        begin
            nv = up_reg;
        end
        else
        begin
            nv = nv_raw;
        end
    end

    // Multiplier store writes: initial copy or row update.
    assign mul_we    = cp_v_reg || (state_reg == S_UPD);
    assign mul_waddr = cp_v_reg ? cp_a_reg[AW-1:0] : i_reg[AW-1:0];
    assign mul_wdata = cp_v_reg ? rhs_q : nv;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        cp_v_next  = 1'b0;
        cp_a_next  = j_reg;
        s1_v_next  = 1'b0;
        o_v_next   = 1'b0;
        o_a_next   = j_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop && head.op == psbl_pkg::OP_SOLVE && n_solve != '0)
                begin
                    n_next     = n_solve;
                    j_next     = '0;
                    state_next = S_COPY;
                end
            end
            S_COPY:
            begin
                if (j_reg < n_reg)
                begin
                    cp_v_next = 1'b1;
                    j_next    = j_reg + 1'b1;
                end
                else if (!cp_v_reg)
                begin
                    i_next = '0;
                    k_next = '0;
                    j_next = '0;
                    state_next = (cfg.sweep_count == '0) ? S_OUT : S_ROW;
                end
            end
            S_ROW:
            begin
                state_next = S_DIAG;
            end
            S_DIAG:
            begin
                j_next     = '0;
                state_next = (mat_q == '0) ? S_NEXT : S_SUM;
            end
            S_SUM:
            begin
                s1_v_next = (j_reg != i_reg);
                j_next    = j_reg + 1'b1;
                if (j_reg == n_reg - 1'b1)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!s1_v_reg && !s2_v_reg)
                begin
                    state_next = S_RES;
                end
            end
            S_RES:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (i_reg == n_reg - 1'b1)
                begin
                    i_next = '0;
                    if (k_reg == cfg.sweep_count - 1'b1)
                    begin
                        j_next     = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_ROW;
                    end
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_ROW;
                end
            end
            S_OUT:
            begin
                o_v_next = 1'b1;
                j_next   = j_reg + 1'b1;
                if (j_reg == n_reg - 1'b1)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            cp_v_reg  <= 1'b0;
            cp_a_reg  <= '0;
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            o_v_reg   <= 1'b0;
            o_a_reg   <= '0;
            done_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            cp_v_reg  <= cp_v_next;
            cp_a_reg  <= cp_a_next;
            s1_v_reg  <= s1_v_next;
            s2_v_reg  <= s1_v_reg;
            o_v_reg   <= o_v_next;
            o_a_reg   <= o_a_next;
            done_reg  <= o_v_reg;
            last_reg  <= o_v_reg && (o_a_reg == n_reg - 1'b1);
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DIAG)
        begin
            diag_reg <= $signed(mat_q);
            rhs_reg  <= $signed(rhs_q);
            lo_reg   <= $signed(lo_q);
            up_reg   <= $signed(up_q);
            sum_reg  <= '0;
        end
        else if (s2_v_reg)
        begin
            sum_reg <= psbl_pkg::sat32(64'(sum_reg) + (prod_reg >>> FRAC_BITS));
        end
        if (s1_v_reg)
        begin
            prod_reg <= $signed(mat_q) * $signed(mul_q);
        end
        if (state_reg == S_RES)
        begin
            m_reg <= $signed(mul_q);
        end
        if (state_reg == S_DIV && div_done)
        begin
            d_reg <= psbl_pkg::sat32(64'(div_q) - 64'(m_reg));
        end
        if (state_reg == S_MUL)
        begin
            rp_reg <= d_reg * $signed({1'b0, cfg.relaxation});
        end
        if (o_v_reg)
        begin
            ri_reg <= 6'(o_a_reg[AW-1:0]);
            mo_reg <= $signed(mul_q);
            zd_reg <= (mat_q == '0);
        end
    end

    assign done          = done_reg;
    assign row_index     = ri_reg;
    assign multiplier    = mo_reg;
    assign zero_diagonal = zd_reg;
    assign last          = last_reg;

endmodule

/* rtl/projected_sor_box_lcp_solver.sv */
// Loads are accepted every cycle while the two-entry queue has room.
// A solve of n rows and s sweeps first copies the right-hand sides into the multipliers, then
// for each sweep and each row with a nonzero diagonal forms the off-diagonal products and runs
// a bit-serial divide, then reports the results, which come one per cycle on consecutive cycles.
// The receiver cannot stall results. Reset clears the configuration to its defaults and
// empties the queue; stored matrix and row data stay undefined until written.
module projected_sor_box_lcp_solver #(
    parameter int MAX_ROWS  = psbl_pkg::DEF_MAX_ROWS,
    parameter int FRAC_BITS = psbl_pkg::DEF_FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         opcode,
    input  logic [5:0]         row,
    input  logic [5:0]         col,
    input  logic signed [31:0] matrix_value,
    input  logic signed [31:0] rhs_value,
    input  logic signed [31:0] lower_bound,
    input  logic signed [31:0] upper_bound,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [14:0]        cfg_data,
    output logic               done,
    output logic [5:0]         row_index,
    output logic signed [31:0] multiplier,
    output logic               zero_diagonal,
    output logic               last
);

    psbl_pkg::cfg_t cfg_reg;
    psbl_pkg::cmd_t cmd_in;
    psbl_pkg::cmd_t head;
    logic           head_valid;
    logic           pop;

    // Configuration registers.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_count   <= 7'd1;
            cfg_reg.sweep_count <= 8'd10;
            cfg_reg.relaxation  <= 15'd19661;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                psbl_pkg::CFG_ROW_COUNT:   cfg_reg.row_count   <= cfg_data[6:0];
                psbl_pkg::CFG_SWEEP_COUNT: cfg_reg.sweep_count <= cfg_data[7:0];
                psbl_pkg::CFG_RELAXATION:  cfg_reg.relaxation  <= cfg_data;
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cmd_in = '{op: opcode, row: row, col: col, matrix_value: matrix_value,
                      rhs_value: rhs_value, lower_bound: lower_bound,
                      upper_bound: upper_bound};

    psbl_front #(.MAX_ROWS(MAX_ROWS)) u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd_in(cmd_in),
        .head_valid(head_valid), .head(head), .pop(pop));

    psbl_engine #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_engine (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .head_valid(head_valid), .head(head),
        .pop(pop), .done(done), .row_index(row_index), .multiplier(multiplier),
        .zero_diagonal(zero_diagonal), .last(last));

    // The final row is only flagged on a result.
    a_last_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> done)
        else $error("last raised without a result");

    // Results of one solve follow on consecutive cycles with rising row numbers.
    a_rows_consecutive: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !last) |=> (done && row_index == $past(row_index) + 6'd1))
        else $error("result rows not consecutive");

    // No result directly after the final row of a solve.
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done && last) |=> !done)
        else $error("result right after final row");

    // Results start at row zero.
    a_first_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !$past(done)) |-> (row_index == 6'd0))
        else $error("solve results do not start at row zero");

endmodule
